// ===== sv/rlps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the radio link poll supervisor.
// No dependencies; every other file of the block refers to it by scoped names.
package rlps_pkg;

	// Default for the number of node slots built into the block
	localparam int NUM_NODES_DEF = 4;

	// Configuration port
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_REGS = 4;

	localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ADDR_BASE  = 3'd2;

	localparam logic [2:0]  NODE_COUNT_RST = 3'd1;
	localparam logic [15:0] TIMEOUT_RST    = 16'd300;

	// Fixed field widths
	localparam int NODE_W  = 2;
	localparam int FRAME_W = 8;
	localparam int TMR_W   = 16;
	localparam int CNT_ERR_W = 3;

	localparam logic [FRAME_W-1:0] FRAME_FIRST = 8'd1;
	localparam logic [FRAME_W-1:0] FRAME_LAST  = 8'd255;
	localparam logic [FRAME_W-1:0] FRAME_NONE  = 8'd0;

	// Saturation limit of the per-node error and silence counters
	localparam logic [CNT_ERR_W-1:0] ERR_LIMIT = 3'd4;

	// Link states
	localparam logic [1:0] LINK_OK      = 2'd0;
	localparam logic [1:0] LINK_NO_RECV = 2'd1;
	localparam logic [1:0] LINK_NO_ACK  = 2'd2;

	// Event codes
	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_STATUS = 2'd1;
	localparam logic [1:0] REQ_REPORT = 2'd2;
	localparam logic [1:0] REQ_TICK   = 2'd3;

	// Transmit result codes
	localparam logic [7:0] TX_OK     = 8'd0;
	localparam logic [7:0] TX_NO_ACK = 8'd1;
	localparam logic [7:0] TX_NO_CCA = 8'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        length_ok;
		logic [7:0]  status_frame;
		logic [7:0]  tx_result;
		logic [63:0] sender_address;
		logic [15:0] green_raw;
		logic [15:0] motor_raw;
		logic [15:0] firmware_word;
		logic [7:0]  report_flags;
	} req_t;

	typedef struct packed {
		logic        send_valid;
		logic [1:0]  send_node;
		logic [7:0]  send_frame;
		logic        send_report_req;
		logic        update_valid;
		logic [1:0]  update_node;
		logic [1:0]  link_state;
		logic [15:0] green_count;
		logic [15:0] motor_count;
		logic [15:0] firmware_version;
		logic        gyro_present;
	} rsp_t;

	// Event broadcast to one node cell
	typedef struct packed {
		logic        ack_ok;
		logic        count_err;
		logic        count_sil;
		logic        rpt_hit;
		logic [15:0] green;
		logic [15:0] motor;
		logic [15:0] firmware;
		logic        gyro;
	} node_ev_t;

	// Post-event view of one node cell
	typedef struct packed {
		logic [1:0]  link;
		logic [15:0] green;
		logic [15:0] motor;
		logic [15:0] firmware;
		logic        gyro;
	} node_view_t;

endpackage

// ===== sv/rlps_req_if.sv =====
`timescale 1ns / 1ps
// Event channel of the radio link poll supervisor: valid/ready plus payload.
// Depends on rlps_pkg for the payload type.
interface rlps_req_if;
	logic          valid;
	logic          ready;
	rlps_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rlps_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the radio link poll supervisor: valid/ready plus payload.
// Depends on rlps_pkg for the payload type.
interface rlps_rsp_if;
	logic          valid;
	logic          ready;
	rlps_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rlps_node.sv =====
`timescale 1ns / 1ps
// One node cell: saturating error and silence counters, link state, last report.
// Depends on rlps_pkg for the event and view structs.
module rlps_node (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlps_pkg::node_ev_t   ev,
	output logic [1:0]           link_cur,
	output rlps_pkg::node_view_t view_nxt
);

	logic [rlps_pkg::CNT_ERR_W-1:0] fail_q, fail_d, fail_inc;
	logic [rlps_pkg::CNT_ERR_W-1:0] sil_q, sil_d, sil_inc;
	logic [1:0]  link_q, link_d;
	logic [15:0] green_q, green_d;
	logic [15:0] motor_q, motor_d;
	logic [15:0] fw_q, fw_d;
	logic        gyro_q, gyro_d;

	assign fail_inc = fail_q + 3'd1;
	assign sil_inc  = sil_q + 3'd1;

	always_comb begin
		fail_d  = fail_q;
		sil_d   = sil_q;
		link_d  = link_q;
		green_d = green_q;
		motor_d = motor_q;
		fw_d    = fw_q;
		gyro_d  = gyro_q;
		if (ev.rpt_hit) begin
			fail_d  = '0;
			sil_d   = '0;
			link_d  = rlps_pkg::LINK_OK;
			green_d = ev.green;
			motor_d = ev.motor;
			fw_d    = ev.firmware;
			gyro_d  = ev.gyro;
		end
		if (ev.ack_ok) begin
			fail_d = '0;
			if (link_q == rlps_pkg::LINK_NO_ACK) begin
				link_d = rlps_pkg::LINK_NO_RECV;
			end
		end
		// error first, then silence: silence only degrades a link still ok
		if (ev.count_err) begin
			if (fail_inc >= rlps_pkg::ERR_LIMIT) begin
				fail_d = rlps_pkg::ERR_LIMIT;
				link_d = rlps_pkg::LINK_NO_ACK;
			end else begin
				fail_d = fail_inc;
			end
		end
		if (ev.count_sil) begin
			if (sil_inc >= rlps_pkg::ERR_LIMIT) begin
				sil_d = rlps_pkg::ERR_LIMIT;
				if (link_d == rlps_pkg::LINK_OK) begin
					link_d = rlps_pkg::LINK_NO_RECV;
				end
			end else begin
				sil_d = sil_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q  <= '0;
			sil_q   <= '0;
			link_q  <= rlps_pkg::LINK_NO_ACK;
			green_q <= '0;
			motor_q <= '0;
			fw_q    <= '0;
			gyro_q  <= 1'b0;
		end else begin
			fail_q  <= fail_d;
			sil_q   <= sil_d;
			link_q  <= link_d;
			green_q <= green_d;
			motor_q <= motor_d;
			fw_q    <= fw_d;
			gyro_q  <= gyro_d;
		end
	end

	assign link_cur = link_q;
	assign view_nxt = '{link: link_d, green: green_d, motor: motor_d,
		firmware: fw_d, gyro: gyro_d};

endmodule

// ===== sv/radio_link_poll_supervisor_core.sv =====
`timescale 1ns / 1ps
// Radio link poll supervisor, top level. Uses rlps_pkg, rlps_req_if, rlps_rsp_if, rlps_node.
// Each result is registered in the result queue and shown on rsp behind any queued items.
// One event per cycle while the skid of the two-entry result queue (head + skid) is free.
// Reset (arst_n, async, low): polling idle, frame counter 1, node links "no acknowledge",
// counters and report values zero, node_count 1, timeout 300, addresses zero.
module radio_link_poll_supervisor_core #(
	parameter int NUM_NODES = rlps_pkg::NUM_NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rlps_req_if.sink                      req,
	rlps_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rlps_pkg::PADDR_W-1:0]  paddr,
	input  logic [rlps_pkg::PDATA_W-1:0]  pwdata,
	output logic [rlps_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int IDX_W = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
	localparam int CNT_W = $clog2(NUM_NODES + 1);
	localparam int WR_NODES = (NUM_NODES < rlps_pkg::ADDR_REGS) ? NUM_NODES
		: rlps_pkg::ADDR_REGS;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [2:0]  node_count_q;
	logic [15:0] timeout_q;
	logic [63:0] addr_q [NUM_NODES];
	logic        cfg_wr;
	logic [rlps_pkg::REG_IDX_W-1:0] reg_idx;
	logic [rlps_pkg::REG_IDX_W-1:0] addr_off;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[rlps_pkg::PADDR_W-1:3];
	assign addr_off = reg_idx - rlps_pkg::REG_ADDR_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= rlps_pkg::NODE_COUNT_RST;
			timeout_q    <= rlps_pkg::TIMEOUT_RST;
		end else if (cfg_wr) begin
			if (reg_idx == rlps_pkg::REG_NODE_COUNT) begin
				node_count_q <= pwdata[2:0];
			end
			if (reg_idx == rlps_pkg::REG_TIMEOUT) begin
				timeout_q <= pwdata[15:0];
			end
		end
	end

	// Address registers exist for the first four slots; slots past them stay zero.
	for (genvar i = 0; i < NUM_NODES; i++) begin : g_addr
		if (i < rlps_pkg::ADDR_REGS) begin : g_wr
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					addr_q[i] <= '0;
				end else if (cfg_wr && reg_idx == rlps_pkg::REG_ADDR_BASE
						+ rlps_pkg::REG_IDX_W'(i)) begin
					addr_q[i] <= pwdata;
				end
			end
		end else begin : g_zero
			assign addr_q[i] = '0;
		end
	end

	always_comb begin
		prdata = '0;
		priority if (reg_idx == rlps_pkg::REG_NODE_COUNT) begin
			prdata = {61'd0, node_count_q};
		end else if (reg_idx == rlps_pkg::REG_TIMEOUT) begin
			prdata = {48'd0, timeout_q};
		end else if (reg_idx >= rlps_pkg::REG_ADDR_BASE
				&& addr_off < rlps_pkg::REG_IDX_W'(WR_NODES)) begin
			prdata = addr_q[IDX_W'(addr_off)];
		end
	end

	// ------------------------------------------------------------------
	// Polling state
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]             send_idx_q, rep_idx_q, active_node_q;
	logic [rlps_pkg::FRAME_W-1:0] frame_q, active_frame_q, active_frame_d;
	logic                         aw_s_q, aw_s_d, aw_r_q, aw_r_d;
	logic [rlps_pkg::TMR_W-1:0]   timer_q, timer_d, timeout_eff;

	// Effective rotation length and the next transmit slot
	logic [CNT_W-1:0] n_eff, s_mod, r_mod;
	logic [IDX_W-1:0] s_cur, s_nxt, r_nxt;
	logic             sched_req;
	logic [rlps_pkg::FRAME_W-1:0] frame_nxt;

	always_comb begin
		if (node_count_q == 3'd0) begin
			n_eff = CNT_W'(1);
		end else if (node_count_q > NUM_NODES) begin
			n_eff = CNT_W'(NUM_NODES);
		end else begin
			n_eff = CNT_W'(node_count_q);
		end
	end

	// Indices may sit past a count lowered while idle: fold them back
	// by repeated subtraction (the index is below NUM_NODES).
	always_comb begin
		s_mod = CNT_W'(send_idx_q);
		r_mod = CNT_W'(rep_idx_q);
		for (int k = 0; k < NUM_NODES - 1; k++) begin
			if (s_mod >= n_eff) s_mod = s_mod - n_eff;
			if (r_mod >= n_eff) r_mod = r_mod - n_eff;
		end
	end

	assign s_cur     = IDX_W'(s_mod);
	assign sched_req = (s_mod == r_mod);
	// sender runs forward, reporter runs backward
	assign s_nxt = (s_mod + CNT_W'(1) == n_eff) ? '0 : IDX_W'(s_mod + CNT_W'(1));
	assign r_nxt = (r_mod == '0) ? IDX_W'(n_eff - CNT_W'(1))
		: IDX_W'(r_mod - CNT_W'(1));
	assign frame_nxt = (frame_q == rlps_pkg::FRAME_LAST) ? rlps_pkg::FRAME_FIRST
		: frame_q + 8'd1;
	assign timeout_eff = (timeout_q == '0) ? 16'd1 : timeout_q;

	// ------------------------------------------------------------------
	// Report sender lookup: lowest slot within the count whose address matches
	// ------------------------------------------------------------------
	logic             match_found;
	logic [IDX_W-1:0] match_idx;

	always_comb begin
		match_found = 1'b0;
		match_idx   = '0;
		for (int i = 0; i < NUM_NODES; i++) begin
			if (!match_found && CNT_W'(i) < n_eff
					&& addr_q[i] == req.data.sender_address) begin
				match_found = 1'b1;
				match_idx   = IDX_W'(i);
			end
		end
	end

	// ------------------------------------------------------------------
	// Event decode
	// ------------------------------------------------------------------
	logic fire, sched, chk_an;
	logic ev_ack, ev_err, ev_sil, ev_rpt;

	assign fire = req.valid & req.ready;

	always_comb begin
		sched          = 1'b0;
		chk_an         = 1'b0;
		ev_ack         = 1'b0;
		ev_err         = 1'b0;
		ev_sil         = 1'b0;
		ev_rpt         = 1'b0;
		aw_s_d         = aw_s_q;
		aw_r_d         = aw_r_q;
		timer_d        = timer_q;
		active_frame_d = active_frame_q;
		if (fire) begin
			unique case (req.data.req_type)
				rlps_pkg::REQ_START: begin
					// start is ignored while anything is still awaited
					if (!aw_s_q && !aw_r_q) sched = 1'b1;
				end
				rlps_pkg::REQ_STATUS: begin
					if (req.data.length_ok && aw_s_q
							&& req.data.status_frame == active_frame_q) begin
						chk_an         = 1'b1;
						active_frame_d = rlps_pkg::FRAME_NONE;
						aw_s_d         = 1'b0;
						priority if (req.data.tx_result == rlps_pkg::TX_OK) begin
							ev_ack = 1'b1;
						end else if (req.data.tx_result == rlps_pkg::TX_NO_ACK
								|| req.data.tx_result == rlps_pkg::TX_NO_CCA) begin
							aw_r_d = 1'b0;
							ev_err = 1'b1;
						end else begin
							aw_r_d = 1'b0;
						end
						// release the air unless a report is still due
						if (!aw_r_d) begin
							timer_d = '0;
							sched   = 1'b1;
						end
					end
				end
				rlps_pkg::REQ_REPORT: begin
					if (req.data.length_ok && match_found) begin
						ev_rpt = 1'b1;
						// a late report updates the node but releases nothing
						if (aw_r_q && match_idx == active_node_q) begin
							aw_r_d = 1'b0;
							if (!aw_s_q) begin
								timer_d = '0;
								sched   = 1'b1;
							end
						end
					end
				end
				rlps_pkg::REQ_TICK: begin
					if (timer_q != '0) begin
						timer_d = timer_q - 16'd1;
						if (timer_q == 16'd1) begin
							// timeout: charge whatever was still awaited
							chk_an         = 1'b1;
							ev_err         = aw_s_q;
							ev_sil         = aw_r_q;
							aw_s_d         = 1'b0;
							aw_r_d         = 1'b0;
							active_frame_d = rlps_pkg::FRAME_NONE;
							sched          = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (sched) begin
			aw_s_d         = 1'b1;
			aw_r_d         = sched_req;
			timer_d        = timeout_eff;
			active_frame_d = frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_idx_q     <= '0;
			rep_idx_q      <= '0;
			frame_q        <= rlps_pkg::FRAME_FIRST;
			active_node_q  <= '0;
			active_frame_q <= rlps_pkg::FRAME_NONE;
			aw_s_q         <= 1'b0;
			aw_r_q         <= 1'b0;
			timer_q        <= '0;
		end else begin
			aw_s_q         <= aw_s_d;
			aw_r_q         <= aw_r_d;
			timer_q        <= timer_d;
			active_frame_q <= active_frame_d;
			if (sched) begin
				send_idx_q    <= s_nxt;
				frame_q       <= frame_nxt;
				active_node_q <= s_cur;
				if (sched_req) rep_idx_q <= r_nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// Node cells: each sees only the events aimed at its own slot
	// ------------------------------------------------------------------
	rlps_pkg::node_ev_t   node_ev   [NUM_NODES];
	rlps_pkg::node_view_t view_nxt  [NUM_NODES];
	logic [1:0]           link_cur  [NUM_NODES];

	for (genvar i = 0; i < NUM_NODES; i++) begin : g_node
		assign node_ev[i] = '{
			ack_ok:    ev_ack && active_node_q == IDX_W'(i),
			count_err: ev_err && active_node_q == IDX_W'(i),
			count_sil: ev_sil && active_node_q == IDX_W'(i),
			rpt_hit:   ev_rpt && match_idx == IDX_W'(i),
			green:     req.data.green_raw,
			motor:     req.data.motor_raw,
			firmware:  req.data.firmware_word,
			gyro:      req.data.report_flags[0]
		};

		rlps_node u_node (
			.clk      (clk),
			.arst_n   (arst_n),
			.ev       (node_ev[i]),
			.link_cur (link_cur[i]),
			.view_nxt (view_nxt[i])
		);
	end

	// ------------------------------------------------------------------
	// Result assembly
	// ------------------------------------------------------------------
	logic                 upd, res_valid;
	logic [IDX_W-1:0]     un;
	rlps_pkg::node_view_t un_view;
	rlps_pkg::rsp_t       res;

	assign un      = ev_rpt ? match_idx : active_node_q;
	assign un_view = view_nxt[un];
	// status and timeout report a node only when its link state moved
	assign upd = ev_rpt
		|| (chk_an && view_nxt[active_node_q].link != link_cur[active_node_q]);
	assign res_valid = sched || upd;

	always_comb begin
		res = '0;
		if (sched) begin
			res.send_valid      = 1'b1;
			res.send_node       = rlps_pkg::NODE_W'(s_cur);
			res.send_frame      = frame_q;
			res.send_report_req = sched_req;
		end
		if (upd) begin
			res.update_valid     = 1'b1;
			res.update_node      = rlps_pkg::NODE_W'(un);
			res.link_state       = un_view.link;
			res.green_count      = un_view.green;
			res.motor_count      = un_view.motor;
			res.firmware_version = un_view.firmware;
			res.gyro_present     = un_view.gyro;
		end
	end

	// ------------------------------------------------------------------
	// Two-entry result queue: head drives rsp, skid absorbs one item
	// while the head is stalled, so req stays open in that cycle.
	// ------------------------------------------------------------------
	rlps_pkg::rsp_t head_q, skid_q;
	logic           head_v_q, skid_v_q;
	logic           push, pop;

	assign req.ready = !skid_v_q;
	assign push      = fire && res_valid;
	assign pop       = head_v_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push) begin
				if (!head_v_q || pop) begin
					head_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					head_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!head_v_q || pop) begin
				head_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (pop && skid_v_q) begin
			head_q <= skid_q;
		end
	end

	assign rsp.valid = head_v_q;
	assign rsp.data  = head_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Queue fills in order: the skid is never occupied with the head empty.
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> head_v_q)
		else $error("skid entry held while head is empty");

	// A result arriving at a stalled, full head must land in the skid.
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && head_v_q && !rsp.ready) |=> skid_v_q)
		else $error("result lost while head stalled");

	// The timer runs exactly while a status or report is awaited.
	a_timer_tracks_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(aw_s_q || aw_r_q) == (timer_q != '0))
		else $error("wait timer out of step with wait flags");

	// A transmit never carries the reserved frame number.
	a_frame_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sched |-> (frame_q != rlps_pkg::FRAME_NONE))
		else $error("transmit issued with frame zero");

endmodule
